// ===== hw/rtl/mpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and codes for the minimum-first priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

  localparam int VALUE_W = 32;
  localparam int PRI_W   = 8;
  localparam int OCC_W   = 4;
  localparam int WORD_W  = PRI_W + VALUE_W;

  typedef enum logic [0:0] {
    FUNC_ENQ = 1'b0,
    FUNC_DEQ = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

endpackage

// ===== hw/rtl/mpq_if.sv =====
// ----------------------------------------------------------------------------
// mpq channel interfaces
// Command and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mpq_cmd_if;
  logic                                valid;
  logic                                ready;
  mpq_pkg::func_t                      func;
  logic signed [mpq_pkg::VALUE_W-1:0]  in_value;
  logic        [mpq_pkg::PRI_W-1:0]    in_priority;

  modport source (output valid, func, in_value, in_priority, input ready);
  modport sink   (input valid, func, in_value, in_priority, output ready);
endinterface

interface mpq_rsp_if;
  logic                                valid;
  logic                                ready;
  mpq_pkg::status_t                    status;
  logic signed [mpq_pkg::VALUE_W-1:0]  out_value;
  logic        [mpq_pkg::PRI_W-1:0]    out_priority;
  logic        [mpq_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, status, out_value, out_priority, occupancy, input ready);
  modport sink   (input valid, status, out_value, out_priority, occupancy, output ready);
endinterface

// ===== hw/rtl/mpq_ram.sv =====
// ----------------------------------------------------------------------------
// mpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mpq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/min_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// min_priority_queue_core
// Bounded priority queue: entries kept in arrival order in one RAM; a dequeue
// scans for the smallest priority (oldest wins a tie), then closes the gap.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                   | beat
//  cmd     | in  | func, in_value, in_priority               | valid & ready
//  rsp     | out | status, out_value, out_priority, occupancy | valid & ready
//
//  Enqueue, empty dequeue and full enqueue go from accept to the result state.
//  A dequeue scans every entry, shifts those behind the removed one, then
//  enters the result state; the single RAM read port reads one entry per cycle.
//  cmd is ready only when the sequencer is idle; a waiting result holds in
//  the rsp register and stalls only the next result load.
//  Reset (synchronous) empties the queue; RAM contents need no clearing.
// ----------------------------------------------------------------------------
module min_priority_queue_core #(
  parameter int DEPTH = 8
) (
  input  logic          clk,
  input  logic          rst,
  mpq_cmd_if.sink       cmd,
  mpq_rsp_if.source     rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  mpq_pkg::state_t  state;
  logic [CW-1:0]    cnt;
  logic [CW-1:0]    ptr;
  logic             rd_vld;
  logic [CW-1:0]    rd_idx;
  logic [CW-1:0]    best_idx;
  logic [mpq_pkg::PRI_W-1:0]   best_pri;
  logic [mpq_pkg::VALUE_W-1:0] best_val;
  mpq_pkg::status_t res_status;

  logic                         out_valid;
  mpq_pkg::status_t             out_status;
  logic [mpq_pkg::VALUE_W-1:0]  out_value;
  logic [mpq_pkg::PRI_W-1:0]    out_priority;
  logic [mpq_pkg::OCC_W-1:0]    out_occ;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [mpq_pkg::WORD_W-1:0]   ram_wdata;
  logic [mpq_pkg::WORD_W-1:0]   ram_rdata;
  logic [mpq_pkg::PRI_W-1:0]    rd_pri;
  logic [mpq_pkg::VALUE_W-1:0]  rd_val;

  logic           accept;
  logic           full;
  logic           issue;
  logic [CW-1:0]  last_idx;
  logic           take;
  logic [CW-1:0]  best_idx_next;
  logic           slot_free;

  assign accept    = cmd.valid && cmd.ready;
  assign full      = (cnt == CW'(DEPTH));
  assign last_idx  = cnt - CW'(1);
  assign issue     = ((state == mpq_pkg::S_SCAN) || (state == mpq_pkg::S_SHIFT))
                     && (ptr < cnt);
  assign rd_pri    = ram_rdata[mpq_pkg::WORD_W-1 -: mpq_pkg::PRI_W];
  assign rd_val    = ram_rdata[mpq_pkg::VALUE_W-1:0];
  // strict less-than keeps the oldest among equal priorities
  assign take      = (rd_idx == '0) || (rd_pri < best_pri);
  assign best_idx_next = take ? rd_idx : best_idx;
  assign slot_free = !out_valid || rsp.ready;

  assign cmd.ready        = (state == mpq_pkg::S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.out_value    = out_value;
  assign rsp.out_priority = out_priority;
  assign rsp.occupancy    = out_occ;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt[AW-1:0];
    ram_wdata = {cmd.in_priority, cmd.in_value};
    if (state == mpq_pkg::S_IDLE) begin
      ram_we = accept && (cmd.func == mpq_pkg::FUNC_ENQ) && !full;
    end else if ((state == mpq_pkg::S_SHIFT) && rd_vld) begin
      // move the younger entry one place forward
      ram_we    = 1'b1;
      ram_waddr = rd_idx[AW-1:0] - AW'(1);
      ram_wdata = ram_rdata;
    end
  end

  mpq_ram #(
    .WIDTH (mpq_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mpq_pkg::S_IDLE;
      cnt       <= '0;
      ptr       <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld <= issue;
      rd_idx <= ptr;
      if (issue) begin
        ptr <= ptr + CW'(1);
      end
      // a new result load wins over the drain of the old one
      if ((state == mpq_pkg::S_RESULT) && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        mpq_pkg::S_IDLE: begin
          if (accept) begin
            best_pri <= '0;
            best_val <= '0;
            best_idx <= '0;
            ptr      <= '0;
            state    <= mpq_pkg::S_RESULT;
            if (cmd.func == mpq_pkg::FUNC_ENQ) begin
              if (full) begin
                res_status <= mpq_pkg::ST_FULL;
              end else begin
                res_status <= mpq_pkg::ST_ENQ;
                cnt        <= cnt + CW'(1);
              end
            end else if (cnt == '0) begin
              res_status <= mpq_pkg::ST_EMPTY;
            end else begin
              res_status <= mpq_pkg::ST_DEQ;
              state      <= mpq_pkg::S_SCAN;
            end
          end
        end
        mpq_pkg::S_SCAN: begin
          if (rd_vld) begin
            if (take) begin
              best_idx <= rd_idx;
              best_pri <= rd_pri;
              best_val <= rd_val;
            end
            if (rd_idx == last_idx) begin
              if (best_idx_next == last_idx) begin
                cnt   <= last_idx;
                state <= mpq_pkg::S_RESULT;
              end else begin
                ptr   <= best_idx_next + CW'(1);
                state <= mpq_pkg::S_SHIFT;
              end
            end
          end
        end
        mpq_pkg::S_SHIFT: begin
          if (rd_vld && (rd_idx == last_idx)) begin
            cnt   <= last_idx;
            state <= mpq_pkg::S_RESULT;
          end
        end
        mpq_pkg::S_RESULT: begin
          if (slot_free) begin
            state <= mpq_pkg::S_IDLE;
          end
        end
        default: begin
          state <= mpq_pkg::S_IDLE;
        end
      endcase
    end
  end

  // response payload: load when the result slot frees up
  always_ff @(posedge clk) begin
    if ((state == mpq_pkg::S_RESULT) && slot_free) begin
      out_status   <= res_status;
      out_value    <= best_val;
      out_priority <= best_pri;
      out_occ      <= mpq_pkg::OCC_W'(cnt);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("entry count above depth");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == mpq_pkg::S_SCAN) |-> (cnt != '0))
    else $error("scan on an empty queue");

  a_shift_after_best: assert property (@(posedge clk) disable iff (rst)
    ((state == mpq_pkg::S_SHIFT) && rd_vld) |-> (rd_idx > best_idx))
    else $error("shift write at or before the removed entry");

  a_nondeq_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status != mpq_pkg::ST_DEQ))
      |-> ((out_value == '0) && (out_priority == '0)))
    else $error("non-dequeue result carries a payload");

  a_enq_occ: assert property (@(posedge clk) disable iff (rst)
    ((state == mpq_pkg::S_IDLE) && accept && (cmd.func == mpq_pkg::FUNC_ENQ) && !full)
      |=> (cnt == $past(cnt) + CW'(1)))
    else $error("enqueue did not advance the count");

endmodule

// ===== test/min_priority_queue_core_test.sv =====
// ----------------------------------------------------------------------------
// min_priority_queue_core_test
// Self-checking bench for the minimum-first priority queue. A shadow copy of
// the queue predicts every response: status, removed entry and occupancy.
// Directed commands cover the empty and full cases, the value and priority
// extremes and priority ties. Random traffic follows, in phases biased
// toward filling, draining or balance, with random gaps and response stalls outside back-to-back phases.
// ----------------------------------------------------------------------------
module min_priority_queue_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 8;

  typedef struct packed {
    mpq_pkg::status_t                   status;
    logic signed [mpq_pkg::VALUE_W-1:0] value;
    logic        [mpq_pkg::PRI_W-1:0]   pri;
    logic        [mpq_pkg::OCC_W-1:0]   occ;
  } rsp_beat_t;

  logic clk;
  logic rst;

  mpq_cmd_if cmd ();
  mpq_rsp_if rsp ();

  min_priority_queue_core #(
    .DEPTH(DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .rsp(rsp)
  );

  // shadow of the queue contents, oldest entry at index 0
  logic signed [mpq_pkg::VALUE_W-1:0] shadow_value [DEPTH];
  logic        [mpq_pkg::PRI_W-1:0]   shadow_pri   [DEPTH];
  int                                 shadow_count;

  rsp_beat_t rsp_due [$];
  int        errors;
  int        n_cmds;
  int        status_seen [4];
  bit        back_to_back;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d responses outstanding", rsp_due.size());
    $display("simulation failed");
    $finish;
  end

  function automatic rsp_beat_t predict_queue_op(
      input mpq_pkg::func_t f,
      input logic signed [mpq_pkg::VALUE_W-1:0] v,
      input logic [mpq_pkg::PRI_W-1:0] p);
    rsp_beat_t r;
    int        best;
    r = '0;
    if (f == mpq_pkg::FUNC_ENQ) begin
      if (shadow_count >= DEPTH) begin
        r.status = mpq_pkg::ST_FULL;
      end else begin
        shadow_value[shadow_count] = v;
        shadow_pri[shadow_count]   = p;
        shadow_count++;
        r.status = mpq_pkg::ST_ENQ;
      end
    end else if (shadow_count == 0) begin
      r.status = mpq_pkg::ST_EMPTY;
    end else begin
      // strict less-than: the oldest entry wins a tie
      best = 0;
      for (int i = 1; i < shadow_count; i++) begin
        if (shadow_pri[i] < shadow_pri[best]) best = i;
      end
      r.status = mpq_pkg::ST_DEQ;
      r.value  = shadow_value[best];
      r.pri    = shadow_pri[best];
      for (int i = best; i + 1 < shadow_count; i++) begin
        shadow_value[i] = shadow_value[i + 1];
        shadow_pri[i]   = shadow_pri[i + 1];
      end
      shadow_count--;
    end
    r.occ = shadow_count[mpq_pkg::OCC_W-1:0];
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (back_to_back) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_cmd(input mpq_pkg::func_t f,
                          input logic signed [mpq_pkg::VALUE_W-1:0] v,
                          input logic [mpq_pkg::PRI_W-1:0] p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid       <= 1'b1;
    cmd.func        <= f;
    cmd.in_value    <= v;
    cmd.in_priority <= p;
    do @(posedge clk); while (cmd.ready !== 1'b1);
    rsp_due.push_back(predict_queue_op(f, v, p));
    n_cmds++;
  endtask

  // response side: random stalls unless running back to back
  initial begin
    int hold;
    hold = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (back_to_back) begin
        hold = 0;
        rsp.ready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        rsp.ready <= 1'b0;
      end else begin
        hold = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
        rsp.ready <= (hold == 0);
      end
    end
  end

  task automatic check_field(input string name,
                             input logic [mpq_pkg::VALUE_W-1:0] want,
                             input logic [mpq_pkg::VALUE_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    rsp_beat_t want;
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (rsp_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual status %0d value %0h",
                 $time, rsp.status, rsp.out_value);
      end else begin
        want = rsp_due.pop_front();
        check_field("status", mpq_pkg::VALUE_W'(want.status),
                    mpq_pkg::VALUE_W'(rsp.status));
        check_field("out_value", want.value, rsp.out_value);
        check_field("out_priority", mpq_pkg::VALUE_W'(want.pri),
                    mpq_pkg::VALUE_W'(rsp.out_priority));
        check_field("occupancy", mpq_pkg::VALUE_W'(want.occ),
                    mpq_pkg::VALUE_W'(rsp.occupancy));
        status_seen[want.status]++;
      end
    end
  end

  task automatic test_empty_dequeue();
    send_cmd(mpq_pkg::FUNC_DEQ, 32'sh1234_5678, 8'hff);
  endtask

  // extremes of value and priority, with ties on 0, 7 and 255
  task automatic test_fill_to_full();
    send_cmd(mpq_pkg::FUNC_ENQ, 32'sh8000_0000, 8'd255);
    send_cmd(mpq_pkg::FUNC_ENQ, 32'sh7fff_ffff, 8'd0);
    send_cmd(mpq_pkg::FUNC_ENQ, 32'sh0000_0000, 8'd7);
    send_cmd(mpq_pkg::FUNC_ENQ, 32'shffff_ffff, 8'd0);
    send_cmd(mpq_pkg::FUNC_ENQ, 32'sh5555_5555, 8'd7);
    send_cmd(mpq_pkg::FUNC_ENQ, 32'shaaaa_aaaa, 8'd255);
    send_cmd(mpq_pkg::FUNC_ENQ, 32'sh0000_0001, 8'd128);
    send_cmd(mpq_pkg::FUNC_ENQ, 32'sh8000_0001, 8'd0);
  endtask

  task automatic test_enqueue_full();
    send_cmd(mpq_pkg::FUNC_ENQ, 32'sh7fff_ffff, 8'd0);
    send_cmd(mpq_pkg::FUNC_ENQ, 32'sh8000_0000, 8'd255);
  endtask

  task automatic test_drain();
    repeat (DEPTH + 1) begin
      send_cmd(mpq_pkg::FUNC_DEQ, mpq_pkg::VALUE_W'($urandom),
               mpq_pkg::PRI_W'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_traffic(input int n_items);
    int                                 phase_left;
    int                                 enq_pct;
    int                                 r;
    logic signed [mpq_pkg::VALUE_W-1:0] v;
    logic        [mpq_pkg::PRI_W-1:0]   p;
    phase_left = 0;
    enq_pct    = 50;
    for (int i = 0; i < n_items; i++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 120);
        case ($urandom_range(0, 2))
          0:       enq_pct = 80;
          1:       enq_pct = 25;
          default: enq_pct = 50;
        endcase
        back_to_back = ($urandom_range(0, 3) == 0);
      end
      phase_left--;
      r = $urandom_range(0, 9);
      if (r == 0) v = 32'sh8000_0000;
      else if (r == 1) v = 32'sh7fff_ffff;
      else v = mpq_pkg::VALUE_W'($urandom);
      // a narrow priority range half the time to force ties
      r = $urandom_range(0, 9);
      if (r < 5) p = mpq_pkg::PRI_W'($urandom_range(0, 3));
      else if (r == 5) p = 8'd0;
      else if (r == 6) p = 8'd255;
      else p = mpq_pkg::PRI_W'($urandom_range(0, 255));
      send_cmd(($urandom_range(0, 99) < enq_pct) ? mpq_pkg::FUNC_ENQ : mpq_pkg::FUNC_DEQ,
               v, p);
    end
    back_to_back = 1'b0;
  endtask

  initial begin
    int waited;
    errors       = 0;
    n_cmds       = 0;
    shadow_count = 0;
    back_to_back = 1'b0;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
    rst             <= 1'b1;
    cmd.valid       <= 1'b0;
    cmd.func        <= mpq_pkg::FUNC_ENQ;
    cmd.in_value    <= '0;
    cmd.in_priority <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_empty_dequeue();
    test_fill_to_full();
    test_enqueue_full();
    test_drain();
    test_random_traffic(1200);
    cmd.valid <= 1'b0;

    waited = 0;
    while (rsp_due.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    // catch any stray beat after the last expected one
    repeat (40) @(posedge clk);

    if (rsp_due.size() != 0) begin
      errors += rsp_due.size();
      $display("%0t: %0d responses never arrived, next expected status %0d",
               $time, rsp_due.size(), rsp_due[0].status);
    end
    $display("%0d commands: %0d enqueued, %0d dequeued, %0d empty, %0d full",
             n_cmds, status_seen[mpq_pkg::ST_ENQ], status_seen[mpq_pkg::ST_DEQ],
             status_seen[mpq_pkg::ST_EMPTY], status_seen[mpq_pkg::ST_FULL]);
    $display("errors: %0d", errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/mpq_pkg.sv
hw/rtl/mpq_if.sv
hw/rtl/mpq_ram.sv
hw/rtl/min_priority_queue_core.sv
test/min_priority_queue_core_test.sv
